@@ hw/rtl/sed_pkg.sv @@
package sed_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       source_ended;
  } sed_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic       bad_escape;
    logic       last_of_run;
  } sed_out_t;

  localparam int unsigned MAX_RESULTS = 3;

  // Characters of interest
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_V         = 8'h76;
  localparam logic [7:0] CH_A         = 8'h61;

  localparam logic [7:0] CTRL_BS  = 8'h08;
  localparam logic [7:0] CTRL_FF  = 8'h0C;
  localparam logic [7:0] CTRL_CR  = 8'h0D;
  localparam logic [7:0] CTRL_LF  = 8'h0A;
  localparam logic [7:0] CTRL_TAB = 8'h09;
  localparam logic [7:0] CTRL_VT  = 8'h0B;
  localparam logic [7:0] CTRL_BEL = 8'h07;

  // UTF-8 encoding limits and markers
  localparam logic [15:0] UTF8_MAX1  = 16'h007F;
  localparam logic [15:0] UTF8_MAX2  = 16'h07FF;
  localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;

  // {valid, value} for an ASCII hex digit, either case
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic sed_out_t mk_result(input logic [7:0] b, input logic valid,
                                         input logic done, input logic bad);
    sed_out_t r;
    r.out_byte    = valid ? b : 8'h00;
    r.byte_valid  = valid;
    r.string_done = done;
    r.bad_escape  = bad;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

@@ hw/rtl/string_escape_decoder.sv @@
// Output: an item's first result is on dst_item in the cycle after the item is accepted.
// Throughput: one item per cycle while each item gives at most one result and dst_ready
//   is high; an item that gives two or three results (escape pass-through, UTF-8) holds
//   the result register until its results have left, one per cycle while dst_ready is high.
// Reset (rst, synchronous): normal text mode, code unit cleared, result register empty.
module string_escape_decoder import sed_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     src_valid,
  output logic     src_ready,
  input  sed_in_t  src_item,
  output logic     dst_valid,
  input  logic     dst_ready,
  output sed_out_t dst_item
);

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESCAPE = 3'd1,
    MODE_HEX0   = 3'd2,
    MODE_HEX1   = 3'd3,
    MODE_HEX2   = 3'd4,
    MODE_HEX3   = 3'd5
  } mode_t;

  mode_t       mode, mode_next;
  logic [15:0] code_unit, code_unit_next;
  sed_out_t    res [MAX_RESULTS];
  logic [1:0]  count;

  sed_out_t    res_new [MAX_RESULTS];
  logic [1:0]  count_new;
  logic        accept;
  logic        drain;
  logic [4:0]  hex;
  logic [15:0] cu_shift;
  logic [7:0]  c;
  logic        ended;

  assign c         = src_item.in_byte;
  assign ended     = src_item.source_ended;
  assign dst_valid = (count != 2'd0);
  assign dst_item  = res[0];
  assign drain     = dst_valid && dst_ready;
  // Take a new item once the result register is empty or its last result leaves now
  assign src_ready = (count == 2'd0) || (count == 2'd1 && dst_ready);
  assign accept    = src_valid && src_ready;
  assign hex       = ended ? 5'd0 : hex_digit(c);
  assign cu_shift  = {code_unit[11:0], hex[3:0]};

  always_comb begin
    mode_next      = MODE_NORMAL;
    code_unit_next = code_unit;
    count_new      = 2'd0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res_new[i] = mk_result(8'h00, 1'b0, 1'b0, 1'b0);
    end

    case (mode)
      MODE_ESCAPE: begin
        if (ended) begin
          res_new[0] = mk_result(8'h00, 1'b0, 1'b1, 1'b0);
          count_new  = 2'd1;
        end else begin
          count_new = 2'd1;
          case (c)
            CH_U: begin
              code_unit_next = 16'h0000;
              mode_next      = MODE_HEX0;
              count_new      = 2'd0;
            end
            CH_SLASH:     res_new[0] = mk_result(CH_SLASH, 1'b1, 1'b0, 1'b0);
            CH_BACKSLASH: res_new[0] = mk_result(CH_BACKSLASH, 1'b1, 1'b0, 1'b0);
            CH_B:         res_new[0] = mk_result(CTRL_BS, 1'b1, 1'b0, 1'b0);
            CH_F:         res_new[0] = mk_result(CTRL_FF, 1'b1, 1'b0, 1'b0);
            CH_R:         res_new[0] = mk_result(CTRL_CR, 1'b1, 1'b0, 1'b0);
            CH_N:         res_new[0] = mk_result(CTRL_LF, 1'b1, 1'b0, 1'b0);
            CH_T:         res_new[0] = mk_result(CTRL_TAB, 1'b1, 1'b0, 1'b0);
            CH_V:         res_new[0] = mk_result(CTRL_VT, 1'b1, 1'b0, 1'b0);
            CH_A:         res_new[0] = mk_result(CTRL_BEL, 1'b1, 1'b0, 1'b0);
            default: begin
              // unknown escape, quote and NUL included: keep the backslash
              res_new[0] = mk_result(CH_BACKSLASH, 1'b1, 1'b0, 1'b0);
              res_new[1] = mk_result(c, 1'b1, 1'b0, 1'b0);
              count_new  = 2'd2;
            end
          endcase
        end
      end
      MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
        if (!hex[4]) begin
          code_unit_next = 16'h0000;
          res_new[0]     = mk_result(8'h00, 1'b0, 1'b1, 1'b1);
          count_new      = 2'd1;
        end else begin
          code_unit_next = cu_shift;
          if (mode != MODE_HEX3) begin
            mode_next = mode_t'(mode + 3'd1);
          end else if (cu_shift <= UTF8_MAX1) begin
            res_new[0] = mk_result(cu_shift[7:0], 1'b1, 1'b0, 1'b0);
            count_new  = 2'd1;
          end else if (cu_shift <= UTF8_MAX2) begin
            res_new[0] = mk_result(UTF8_LEAD2 | {3'b000, cu_shift[10:6]}, 1'b1, 1'b0, 1'b0);
            res_new[1] = mk_result(UTF8_CONT | {2'b00, cu_shift[5:0]}, 1'b1, 1'b0, 1'b0);
            count_new  = 2'd2;
          end else begin
            res_new[0] = mk_result(UTF8_LEAD3 | {4'b0000, cu_shift[15:12]}, 1'b1, 1'b0,
                                   1'b0);
            res_new[1] = mk_result(UTF8_CONT | {2'b00, cu_shift[11:6]}, 1'b1, 1'b0, 1'b0);
            res_new[2] = mk_result(UTF8_CONT | {2'b00, cu_shift[5:0]}, 1'b1, 1'b0, 1'b0);
            count_new  = 2'd3;
          end
        end
      end
      default: begin
        if (ended || c == CH_NUL || c == CH_QUOTE) begin
          res_new[0] = mk_result(8'h00, 1'b0, 1'b1, 1'b0);
          count_new  = 2'd1;
        end else if (c == CH_BACKSLASH) begin
          mode_next = MODE_ESCAPE;
        end else begin
          res_new[0] = mk_result(c, 1'b1, 1'b0, 1'b0);
          count_new  = 2'd1;
        end
      end
    endcase

    if (count_new != 2'd0) begin
      res_new[count_new - 2'd1].last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_NORMAL;
      code_unit <= 16'h0000;
      count     <= 2'd0;
    end else if (accept) begin
      mode      <= mode_next;
      code_unit <= code_unit_next;
      count     <= count_new;
      for (int i = 0; i < MAX_RESULTS; i++) begin
        res[i] <= res_new[i];
      end
    end else if (drain) begin
      count <= count - 2'd1;
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        res[i] <= res[i + 1];
      end
    end
  end

endmodule

@@ test/string_escape_decoder_chk.sv @@
module string_escape_decoder_chk import sed_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     src_valid,
  input  logic     src_ready,
  input  sed_in_t  src_item,
  input  logic     dst_valid,
  input  logic     dst_ready,
  input  sed_out_t dst_item,
  output int       fail_cnt,
  output int       pending,
  output int       n_items,
  output int       n_results,
  output int       n_done,
  output int       n_bad
);

  typedef enum logic [2:0] {
    DEC_TEXT = 3'd0,
    DEC_ESC  = 3'd1,
    DEC_HEX0 = 3'd2,
    DEC_HEX1 = 3'd3,
    DEC_HEX2 = 3'd4,
    DEC_HEX3 = 3'd5
  } dec_mode_t;

  dec_mode_t   dec_mode;
  logic [15:0] code_acc;
  sed_out_t    decoded_q [$];
  sed_out_t    want;

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic sed_out_t result_of(input logic [7:0] b, input logic v,
                                         input logic d, input logic e);
    sed_out_t r;
    r.out_byte    = b;
    r.byte_valid  = v;
    r.string_done = d;
    r.bad_escape  = e;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // Works out the decoded bytes one input item gives and queues them.
  task automatic decode_item(input sed_in_t it);
    sed_out_t res [3];
    int n;
    int h;
    n = 0;
    h = 0;
    case (dec_mode)
      DEC_ESC: begin
        dec_mode = DEC_TEXT;
        if (it.source_ended) begin
          // lone backslash at the end is dropped
          res[0] = result_of(8'h00, 1'b0, 1'b1, 1'b0);
          n = 1;
        end else begin
          n = 1;
          case (it.in_byte)
            CH_U: begin
              code_acc = '0;
              dec_mode = DEC_HEX0;
              n = 0;
            end
            CH_SLASH, CH_BACKSLASH: res[0] = result_of(it.in_byte, 1'b1, 1'b0, 1'b0);
            CH_B: res[0] = result_of(CTRL_BS, 1'b1, 1'b0, 1'b0);
            CH_F: res[0] = result_of(CTRL_FF, 1'b1, 1'b0, 1'b0);
            CH_R: res[0] = result_of(CTRL_CR, 1'b1, 1'b0, 1'b0);
            CH_N: res[0] = result_of(CTRL_LF, 1'b1, 1'b0, 1'b0);
            CH_T: res[0] = result_of(CTRL_TAB, 1'b1, 1'b0, 1'b0);
            CH_V: res[0] = result_of(CTRL_VT, 1'b1, 1'b0, 1'b0);
            CH_A: res[0] = result_of(CTRL_BEL, 1'b1, 1'b0, 1'b0);
            default: begin
              // unknown escape, NUL and quote included: kept verbatim
              res[0] = result_of(CH_BACKSLASH, 1'b1, 1'b0, 1'b0);
              res[1] = result_of(it.in_byte, 1'b1, 1'b0, 1'b0);
              n = 2;
            end
          endcase
        end
      end
      DEC_HEX0, DEC_HEX1, DEC_HEX2, DEC_HEX3: begin
        h = it.source_ended ? -1 : hex_nibble(it.in_byte);
        if (h < 0) begin
          dec_mode = DEC_TEXT;
          code_acc = '0;
          res[0] = result_of(8'h00, 1'b0, 1'b1, 1'b1);
          n = 1;
        end else begin
          code_acc = {code_acc[11:0], h[3:0]};
          if (dec_mode != DEC_HEX3) begin
            dec_mode = dec_mode_t'(dec_mode + 3'd1);
          end else begin
            dec_mode = DEC_TEXT;
            if (code_acc <= UTF8_MAX1) begin
              res[0] = result_of(code_acc[7:0], 1'b1, 1'b0, 1'b0);
              n = 1;
            end else if (code_acc <= UTF8_MAX2) begin
              res[0] = result_of(UTF8_LEAD2 | {3'b000, code_acc[10:6]}, 1'b1, 1'b0, 1'b0);
              res[1] = result_of(UTF8_CONT | {2'b00, code_acc[5:0]}, 1'b1, 1'b0, 1'b0);
              n = 2;
            end else begin
              // surrogates land here too, three bytes each
              res[0] = result_of(UTF8_LEAD3 | {4'h0, code_acc[15:12]}, 1'b1, 1'b0, 1'b0);
              res[1] = result_of(UTF8_CONT | {2'b00, code_acc[11:6]}, 1'b1, 1'b0, 1'b0);
              res[2] = result_of(UTF8_CONT | {2'b00, code_acc[5:0]}, 1'b1, 1'b0, 1'b0);
              n = 3;
            end
          end
        end
      end
      default: begin
        dec_mode = DEC_TEXT;
        if (it.source_ended || it.in_byte == CH_NUL || it.in_byte == CH_QUOTE) begin
          res[0] = result_of(8'h00, 1'b0, 1'b1, 1'b0);
          n = 1;
        end else if (it.in_byte == CH_BACKSLASH) begin
          dec_mode = DEC_ESC;
        end else begin
          res[0] = result_of(it.in_byte, 1'b1, 1'b0, 1'b0);
          n = 1;
        end
      end
    endcase
    if (n > 0) res[n-1].last_of_run = 1'b1;
    for (int k = 0; k < n; k++) decoded_q = {decoded_q, res[k]};
  endtask

  task automatic report_field(input string name, input logic [7:0] exp_v,
                              input logic [7:0] got_v);
    $display("%0t: %s mismatch, expected %02h actual %02h", $time, name, exp_v, got_v);
    fail_cnt++;
  endtask

  initial begin
    fail_cnt  = 0;
    pending   = 0;
    n_items   = 0;
    n_results = 0;
    n_done    = 0;
    n_bad     = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      dec_mode = DEC_TEXT;
      code_acc = '0;
      decoded_q.delete();
    end else begin
      if (dst_valid && dst_ready) begin
        n_results++;
        if (dst_item.string_done) n_done++;
        if (dst_item.bad_escape) n_bad++;
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected item, expected none actual %p", $time, dst_item);
          fail_cnt++;
        end else begin
          want = decoded_q.pop_front();
          if (want.out_byte !== dst_item.out_byte)
            report_field("out_byte", want.out_byte, dst_item.out_byte);
          if (want.byte_valid !== dst_item.byte_valid)
            report_field("byte_valid", {7'b0, want.byte_valid}, {7'b0, dst_item.byte_valid});
          if (want.string_done !== dst_item.string_done)
            report_field("string_done", {7'b0, want.string_done},
                         {7'b0, dst_item.string_done});
          if (want.bad_escape !== dst_item.bad_escape)
            report_field("bad_escape", {7'b0, want.bad_escape}, {7'b0, dst_item.bad_escape});
          if (want.last_of_run !== dst_item.last_of_run)
            report_field("last_of_run", {7'b0, want.last_of_run},
                         {7'b0, dst_item.last_of_run});
        end
      end
      if (src_valid && src_ready) begin
        n_items++;
        decode_item(src_item);
      end
    end
    pending <= decoded_q.size();
  end

endmodule

@@ test/string_escape_decoder_tb.sv @@
module string_escape_decoder_tb import sed_pkg::*;;

  localparam int WATCHDOG    = 2000;
  localparam int HOLD_CYCLES = 60;

  logic     clk = 1'b0;
  logic     rst;
  logic     src_valid;
  logic     src_ready;
  sed_in_t  src_item;
  logic     dst_valid;
  logic     dst_ready;
  sed_out_t dst_item;

  int fail_cnt, pending, n_items, n_results, n_done, n_bad;
  int tx_idle_pct = 11;
  int rx_idle_pct = 74;
  int items_sent  = 0;
  int quiet       = 0;
  bit hold_req    = 1'b0;

  always #6 clk = ~clk;

  string_escape_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_item  (src_item),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_item  (dst_item)
  );

  string_escape_decoder_chk chk (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_item  (src_item),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_item  (dst_item),
    .fail_cnt  (fail_cnt),
    .pending   (pending),
    .n_items   (n_items),
    .n_results (n_results),
    .n_done    (n_done),
    .n_bad     (n_bad)
  );

  task automatic send_item(input logic [7:0] b, input logic ended);
    sed_in_t it;
    it.in_byte      = b;
    it.source_ended = ended;
    while ($urandom_range(99) < tx_idle_pct) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    src_item  <= it;
    @(posedge clk);
    while (!src_ready) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return "0" + {4'h0, v};
    return ($urandom_range(1) ? "A" : "a") + {4'h0, v} - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"))
      b = "g";
    return b;
  endfunction

  function automatic logic [7:0] mapped_escape();
    case ($urandom_range(8))
      0: return CH_SLASH;
      1: return CH_BACKSLASH;
      2: return CH_B;
      3: return CH_F;
      4: return CH_R;
      5: return CH_N;
      6: return CH_T;
      7: return CH_V;
      default: return CH_A;
    endcase
  endfunction

  task automatic send_unicode(input logic [15:0] cu);
    send_item(CH_BACKSLASH, 1'b0);
    send_item(CH_U, 1'b0);
    for (int k = 3; k >= 0; k--) send_item(hex_char(cu[k*4 +: 4]), 1'b0);
  endtask

  task automatic send_random_token();
    int pick;
    int good;
    logic [15:0] cu;
    pick = $urandom_range(99);
    if (pick < 35) begin
      send_item(8'($urandom_range(255)), 1'b0);
    end else if (pick < 55) begin
      send_item(CH_BACKSLASH, 1'b0);
      send_item(mapped_escape(), 1'b0);
    end else if (pick < 75) begin
      case ($urandom_range(3))
        0: cu = 16'($urandom_range(16'h007F));
        1: cu = 16'($urandom_range(16'h07FF, 16'h0080));
        2: cu = 16'($urandom_range(16'hFFFF, 16'h0800));
        default: begin
          case ($urandom_range(5))
            0: cu = 16'h0000;
            1: cu = UTF8_MAX1;
            2: cu = UTF8_MAX1 + 16'd1;
            3: cu = UTF8_MAX2;
            4: cu = UTF8_MAX2 + 16'd1;
            default: cu = 16'hFFFF;
          endcase
        end
      endcase
      send_unicode(cu);
    end else if (pick < 82) begin
      send_item(CH_BACKSLASH, 1'b0);
      send_item(8'($urandom_range(255)), 1'b0);
    end else if (pick < 90) begin
      case ($urandom_range(2))
        0: send_item(CH_NUL, 1'b0);
        1: send_item(CH_QUOTE, 1'b0);
        default: send_item(8'($urandom_range(255)), 1'b1);
      endcase
    end else begin
      // broken escapes: cut short or bad digit
      send_item(CH_BACKSLASH, 1'b0);
      if ($urandom_range(4) == 0) begin
        send_item(8'($urandom_range(255)), 1'b1);
      end else begin
        send_item(CH_U, 1'b0);
        good = $urandom_range(3);
        for (int k = 0; k < good; k++) send_item(hex_char(4'($urandom_range(15))), 1'b0);
        if ($urandom_range(1)) send_item(non_hex_byte(), 1'b0);
        else send_item(8'($urandom_range(255)), 1'b1);
      end
    end
  endtask

  task automatic drain();
    src_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // receiver: random stalls, or one long hold-off when asked
  initial begin
    dst_ready <= 1'b0;
    forever begin
      if (hold_req) begin
        dst_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        dst_ready <= ($urandom_range(99) >= rx_idle_pct);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (src_valid && src_ready) || (dst_valid && dst_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    src_valid <= 1'b0;
    src_item  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // plain bytes and the three terminators
    send_item(8'h41, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(CH_QUOTE, 1'b0);
    send_item(CH_NUL, 1'b0);
    send_item(8'hA5, 1'b1);
    // source ends right after a backslash
    send_item(CH_BACKSLASH, 1'b0);
    send_item(8'h5A, 1'b1);
    // escaped NUL and escaped quote do not end the string
    send_item(CH_BACKSLASH, 1'b0);
    send_item(CH_NUL, 1'b0);
    send_item(CH_BACKSLASH, 1'b0);
    send_item(CH_QUOTE, 1'b0);
    // bad hex digit, then source end inside \u
    send_item(CH_BACKSLASH, 1'b0);
    send_item(CH_U, 1'b0);
    send_item("1", 1'b0);
    send_item("G", 1'b0);
    send_item(CH_BACKSLASH, 1'b0);
    send_item(CH_U, 1'b0);
    send_item(8'hFF, 1'b1);
    // lone surrogate
    send_unicode(16'hD83D);

    while (items_sent < 120) send_random_token();
    drain();

    tx_idle_pct = 74;
    rx_idle_pct = 11;
    while (items_sent < 215) send_random_token();
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b1;
    while (items_sent < 310) send_random_token();
    drain();
    repeat (8) @(posedge clk);

    $display("summary: %0d bytes in, %0d items out, %0d strings ended, %0d bad escapes",
             n_items, n_results, n_done, n_bad);
    $display("summary: idling in both directions, a long output hold-off and drained pauses");
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
